>>> sv/licu_pkg.sv
// ----------------------------------------------------------------------------
// licu_pkg: shared constants and types of the lattice invasion cell update
// Fixed-point widths, register indexes and the sideband record that travels
// with each item through the strength dividers.
// ----------------------------------------------------------------------------
package licu_pkg;

    // Fitness is unsigned Q8.24, probabilities and randoms unsigned Q0.16
    localparam int FIT_W  = 32;
    localparam int PROB_W = 16;

    // Truncate fitness operands when the products would get too wide
    localparam int PROD_SHIFT = (FIT_W + PROB_W + 1 > 61) ? (FIT_W + PROB_W + 1 - 61) : 0;
    localparam int OP_W       = FIT_W - PROD_SHIFT;

    // p*n + (1-p)*c stays below 2^(OP_W+PROB_W)
    localparam int DEN_W = OP_W + PROB_W;

    // Strength quotient is 0..2^PROB_W inclusive
    localparam int QUO_W = PROB_W + 1;

    // Width of the weighted-choice products
    localparam int CMP_W = 2 * PROB_W + 2;

    // Configuration port
    localparam int IDX_W = 2;

    localparam logic [IDX_W-1:0] REG_BIRTH_SHARE   = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_INVASION_RATE = IDX_W'(1);

    localparam logic [PROB_W-1:0] BIRTH_SHARE_RST   = PROB_W'(6554);
    localparam logic [PROB_W-1:0] INVASION_RATE_RST = PROB_W'(13107);

    // Item fields that ride along with the arithmetic
    typedef struct packed {
        logic [FIT_W-1:0]  left_fit;
        logic [FIT_W-1:0]  center_fit;
        logic [FIT_W-1:0]  right_fit;
        logic [PROB_W-1:0] gate;
        logic [PROB_W-1:0] pick;
        logic              attempt;
    } licu_side_t;

endpackage

>>> sv/licu_strength_div.sv
// ----------------------------------------------------------------------------
// licu_strength_div: pipelined fractional dividers for both strengths
// Computes floor(num * 2^PROB_W / den) for the left and right neighbours with
// one restoring step per stage, and carries the item sideband alongside.
// ----------------------------------------------------------------------------
module licu_strength_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic [licu_pkg::DEN_W-1:0] num_l,
    input  logic [licu_pkg::DEN_W-1:0] den_l,
    input  logic [licu_pkg::DEN_W-1:0] num_r,
    input  logic [licu_pkg::DEN_W-1:0] den_r,
    input  licu_pkg::licu_side_t       in_side,
    output logic                       out_valid,
    output logic [licu_pkg::QUO_W-1:0] str_l,
    output logic [licu_pkg::QUO_W-1:0] str_r,
    output licu_pkg::licu_side_t       out_side
);
    import licu_pkg::*;

    localparam int NSTEP = QUO_W;

    // Stage registers, one entry per quotient bit
    logic             valid_reg [NSTEP];
    logic [DEN_W-1:0] rem_l_reg [NSTEP];
    logic [DEN_W-1:0] rem_r_reg [NSTEP];
    logic [DEN_W-1:0] den_l_reg [NSTEP];
    logic [DEN_W-1:0] den_r_reg [NSTEP];
    logic [QUO_W-1:0] quo_l_reg [NSTEP];
    logic [QUO_W-1:0] quo_r_reg [NSTEP];
    licu_side_t       side_reg  [NSTEP];

    for (genvar k = 0; k < NSTEP; k++) begin : g_step
        logic             cur_valid;
        logic [DEN_W-1:0] cur_rem_l;
        logic [DEN_W-1:0] cur_rem_r;
        logic [DEN_W-1:0] cur_den_l;
        logic [DEN_W-1:0] cur_den_r;
        logic [QUO_W-1:0] cur_quo_l;
        logic [QUO_W-1:0] cur_quo_r;
        licu_side_t       cur_side;
        logic [DEN_W:0]   ext_l;
        logic [DEN_W:0]   ext_r;
        logic             bit_l;
        logic             bit_r;
        logic [DEN_W-1:0] rem_l_next;
        logic [DEN_W-1:0] rem_r_next;

        // Select the stage input: the ports for the first step
        if (k == 0) begin : g_first
            assign cur_valid = in_valid;
            assign cur_rem_l = num_l;
            assign cur_rem_r = num_r;
            assign cur_den_l = den_l;
            assign cur_den_r = den_r;
            assign cur_quo_l = '0;
            assign cur_quo_r = '0;
            assign cur_side  = in_side;
            // First step compares the numerator unshifted
            assign ext_l = {1'b0, cur_rem_l};
            assign ext_r = {1'b0, cur_rem_r};
        end
        else begin : g_next
            assign cur_valid = valid_reg[k-1];
            assign cur_rem_l = rem_l_reg[k-1];
            assign cur_rem_r = rem_r_reg[k-1];
            assign cur_den_l = den_l_reg[k-1];
            assign cur_den_r = den_r_reg[k-1];
            assign cur_quo_l = quo_l_reg[k-1];
            assign cur_quo_r = quo_r_reg[k-1];
            assign cur_side  = side_reg[k-1];
            assign ext_l = {cur_rem_l, 1'b0};
            assign ext_r = {cur_rem_r, 1'b0};
        end

        // Restoring step: compare and subtract
        always_comb
        begin
            bit_l = (ext_l >= {1'b0, cur_den_l});
            bit_r = (ext_r >= {1'b0, cur_den_r});
            rem_l_next = bit_l ? DEN_W'(ext_l - {1'b0, cur_den_l}) : ext_l[DEN_W-1:0];
            rem_r_next = bit_r ? DEN_W'(ext_r - {1'b0, cur_den_r}) : ext_r[DEN_W-1:0];
        end

        // Advance the valid bit
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else
            begin
                valid_reg[k] <= cur_valid;
            end
        end

        // Advance the payload
        always_ff @(posedge clk)
        begin
            rem_l_reg[k] <= rem_l_next;
            rem_r_reg[k] <= rem_r_next;
            den_l_reg[k] <= cur_den_l;
            den_r_reg[k] <= cur_den_r;
            quo_l_reg[k] <= {cur_quo_l[QUO_W-2:0], bit_l};
            quo_r_reg[k] <= {cur_quo_r[QUO_W-2:0], bit_r};
            side_reg[k]  <= cur_side;
        end
    end

    assign out_valid = valid_reg[NSTEP-1];
    assign str_l     = quo_l_reg[NSTEP-1];
    assign str_r     = quo_r_reg[NSTEP-1];
    assign out_side  = side_reg[NSTEP-1];

endmodule

>>> sv/lattice_invasion_cell_update_top.sv
// ----------------------------------------------------------------------------
// lattice_invasion_cell_update_top: per-cell invasion rule, fully pipelined
// Computes both neighbour strengths, gates and accepts the attempt, picks a
// side and replaces the center fitness when the chosen neighbour differs.
// ----------------------------------------------------------------------------
//  channel   | handshake               | payload
//  ----------+-------------------------+---------------------------------------
//  item in   | start, busy             | left/center/right_fitness, gate/pick_random
//  result    | done (one-cycle strobe) | new_fitness, replaced, chosen_side
//  config    | write_en                | reg_index, write_data
//
//  One item per cycle; busy stays low, so every start is taken.
//  A result shows on done after its item passes through the input
//  register, multiply, add, 17 restoring divider steps, choice products,
//  compare and output register.
//  Reset clears the valid bits and loads the register defaults.
//  The receiver cannot stall, so the pipeline never holds.
// ----------------------------------------------------------------------------
module lattice_invasion_cell_update_top (
    input  logic                        clk,
    input  logic                        rst_n,
    // item in
    input  logic                        start,
    output logic                        busy,
    input  logic [licu_pkg::FIT_W-1:0]  left_fitness,
    input  logic [licu_pkg::FIT_W-1:0]  center_fitness,
    input  logic [licu_pkg::FIT_W-1:0]  right_fitness,
    input  logic [licu_pkg::PROB_W-1:0] gate_random,
    input  logic [licu_pkg::PROB_W-1:0] pick_random,
    // result
    output logic                        done,
    output logic [licu_pkg::FIT_W-1:0]  new_fitness,
    output logic                        replaced,
    output logic                        chosen_side,
    // configuration
    input  logic                        write_en,
    input  logic [licu_pkg::IDX_W-1:0]  reg_index,
    input  logic [licu_pkg::PROB_W-1:0] write_data
);
    import licu_pkg::*;

    localparam logic [PROB_W:0] PROB_ONE = {1'b1, {PROB_W{1'b0}}};

    // Configuration registers
    logic [PROB_W-1:0] birth_share_reg;
    logic [PROB_W-1:0] invasion_rate_reg;

    // Stage 1: input capture
    logic              v1_reg;
    licu_side_t        side1_reg;

    // Stage 2: products
    logic              v2_reg;
    licu_side_t        side2_reg;
    logic [DEN_W-1:0]  al_reg;
    logic [DEN_W-1:0]  ar_reg;
    logic [DEN_W-1:0]  bc_reg;
    logic [DEN_W-1:0]  al_next;
    logic [DEN_W-1:0]  ar_next;
    logic [DEN_W-1:0]  bc_next;
    logic [PROB_W:0]   q_share;
    logic [OP_W-1:0]   left_op;
    logic [OP_W-1:0]   center_op;
    logic [OP_W-1:0]   right_op;

    // Stage 3: denominators
    logic              v3_reg;
    licu_side_t        side3_reg;
    licu_side_t        side3_next;
    logic [DEN_W-1:0]  al3_reg;
    logic [DEN_W-1:0]  ar3_reg;
    logic [DEN_W-1:0]  dl_reg;
    logic [DEN_W-1:0]  dr_reg;
    logic [DEN_W-1:0]  dl_next;
    logic [DEN_W-1:0]  dr_next;

    // Divider outputs
    logic              vd;
    logic [QUO_W-1:0]  str_l;
    logic [QUO_W-1:0]  str_r;
    licu_side_t        sided;

    // Stage 4: acceptance and choice products
    logic              v4_reg;
    licu_side_t        side4_reg;
    logic              accept4_reg;
    logic [CMP_W-1:0]  prod_r_reg;
    logic [CMP_W-1:0]  prod_l_reg;
    logic              accept4_next;
    logic [PROB_W+1:0] str_sum;
    logic [PROB_W:0]   pick_inv;

    // Stage 5: side decision
    logic              v5_reg;
    licu_side_t        side5_reg;
    logic              accept5_reg;
    logic              go_right5_reg;

    // Output stage
    logic              done_reg;
    logic [FIT_W-1:0]  new_fitness_reg;
    logic              replaced_reg;
    logic              chosen_side_reg;
    logic [FIT_W-1:0]  chosen;
    logic              rep_next;

    // Always ready: one item per cycle
    assign busy = 1'b0;

    // Decode configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            birth_share_reg   <= BIRTH_SHARE_RST;
            invasion_rate_reg <= INVASION_RATE_RST;
        end
        else if (write_en)
        begin
            unique case (reg_index)
                REG_BIRTH_SHARE:   birth_share_reg   <= write_data;
                REG_INVASION_RATE: invasion_rate_reg <= write_data;
                default:           ;
            endcase
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            v5_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= start & ~busy;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            v4_reg   <= vd;
            v5_reg   <= v4_reg;
            done_reg <= v5_reg;
        end
    end

    // Stage 1: capture the item and test the gate
    always_ff @(posedge clk)
    begin
        side1_reg.left_fit   <= left_fitness;
        side1_reg.center_fit <= center_fitness;
        side1_reg.right_fit  <= right_fitness;
        side1_reg.gate       <= gate_random;
        side1_reg.pick       <= pick_random;
        side1_reg.attempt    <= (gate_random < invasion_rate_reg);
    end

    // Stage 2: strength numerators and the center term
    always_comb
    begin
        q_share   = PROB_ONE - {1'b0, birth_share_reg};
        left_op   = side1_reg.left_fit[FIT_W-1:PROD_SHIFT];
        center_op = side1_reg.center_fit[FIT_W-1:PROD_SHIFT];
        right_op  = side1_reg.right_fit[FIT_W-1:PROD_SHIFT];
        al_next   = DEN_W'(birth_share_reg) * DEN_W'(left_op);
        ar_next   = DEN_W'(birth_share_reg) * DEN_W'(right_op);
        bc_next   = DEN_W'(q_share) * DEN_W'(center_op);
    end

    always_ff @(posedge clk)
    begin
        side2_reg <= side1_reg;
        al_reg    <= al_next;
        ar_reg    <= ar_next;
        bc_reg    <= bc_next;
    end

    // Stage 3: denominators; drop the attempt on a zero denominator
    always_comb
    begin
        dl_next            = al_reg + bc_reg;
        dr_next            = ar_reg + bc_reg;
        side3_next         = side2_reg;
        side3_next.attempt = side2_reg.attempt & (dl_next != '0) & (dr_next != '0);
    end

    always_ff @(posedge clk)
    begin
        side3_reg <= side3_next;
        al3_reg   <= al_reg;
        ar3_reg   <= ar_reg;
        dl_reg    <= dl_next;
        dr_reg    <= dr_next;
    end

    // Strength dividers
    licu_strength_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v3_reg),
        .num_l     (al3_reg),
        .den_l     (dl_reg),
        .num_r     (ar3_reg),
        .den_r     (dr_reg),
        .in_side   (side3_reg),
        .out_valid (vd),
        .str_l     (str_l),
        .str_r     (str_r),
        .out_side  (sided)
    );

    // Stage 4: accept test and weighted-choice products
    always_comb
    begin
        str_sum      = {1'b0, str_l} + {1'b0, str_r};
        accept4_next = sided.attempt & ({1'b0, sided.gate, 1'b0} <= str_sum);
        pick_inv     = PROB_ONE - {1'b0, sided.pick};
    end

    always_ff @(posedge clk)
    begin
        side4_reg   <= sided;
        accept4_reg <= accept4_next;
        prod_r_reg  <= CMP_W'(sided.pick) * CMP_W'(str_r);
        prod_l_reg  <= CMP_W'(str_l) * CMP_W'(pick_inv);
    end

    // Stage 5: pick the side; a zero pick or a tie goes to the left neighbour
    always_ff @(posedge clk)
    begin
        side5_reg     <= side4_reg;
        accept5_reg   <= accept4_reg;
        go_right5_reg <= (side4_reg.pick != '0) & (prod_r_reg > prod_l_reg);
    end

    // Output stage: replace the center when the chosen value differs
    always_comb
    begin
        chosen   = go_right5_reg ? side5_reg.right_fit : side5_reg.left_fit;
        rep_next = accept5_reg & (chosen != side5_reg.center_fit);
    end

    always_ff @(posedge clk)
    begin
        new_fitness_reg <= rep_next ? chosen : side5_reg.center_fit;
        replaced_reg    <= rep_next;
        chosen_side_reg <= rep_next & go_right5_reg;
    end

    assign done        = done_reg;
    assign new_fitness = new_fitness_reg;
    assign replaced    = replaced_reg;
    assign chosen_side = chosen_side_reg;

endmodule

>>> verif/tb_lattice_invasion_cell_update_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lattice_invasion_cell_update_top: self-checking bench for the cell update
// Drives cells in random bursts through the command port and predicts each
// cell's fate from the neighbour strengths. Every done strobe is checked
// against the oldest prediction. The bench moves through several
// birth_share / invasion_rate settings, the extremes among them.
// ----------------------------------------------------------------------------
module tb_lattice_invasion_cell_update_top;

    import licu_pkg::*;

    localparam int              CYCLE_LIMIT = 200000;
    localparam int              DRAIN_WAIT  = 30;
    localparam logic [PROB_W:0] PROB_ONE    = {1'b1, {PROB_W{1'b0}}};

    // Indexes past the two registers; writes to them must change nothing
    localparam logic [IDX_W-1:0] REG_SPARE_A = IDX_W'(2);
    localparam logic [IDX_W-1:0] REG_SPARE_B = IDX_W'(3);

    typedef struct packed {
        logic [FIT_W-1:0]  left_fit;
        logic [FIT_W-1:0]  center_fit;
        logic [FIT_W-1:0]  right_fit;
        logic [PROB_W-1:0] gate;
        logic [PROB_W-1:0] pick;
    } cell_item_t;

    typedef struct packed {
        logic [FIT_W-1:0] new_fit;
        logic             was_replaced;
        logic             side;
    } cell_fate_t;

    logic                clk            = 1'b0;
    logic                rst_n          = 1'b0;
    logic                start          = 1'b0;
    logic                busy;
    logic [FIT_W-1:0]    left_fitness   = '0;
    logic [FIT_W-1:0]    center_fitness = '0;
    logic [FIT_W-1:0]    right_fitness  = '0;
    logic [PROB_W-1:0]   gate_random    = '0;
    logic [PROB_W-1:0]   pick_random    = '0;
    logic                done;
    logic [FIT_W-1:0]    new_fitness;
    logic                replaced;
    logic                chosen_side;
    logic                write_en       = 1'b0;
    logic [IDX_W-1:0]    reg_index      = '0;
    logic [PROB_W-1:0]   write_data     = '0;

    // Register copies used for prediction
    logic [PROB_W-1:0]   share_cfg = BIRTH_SHARE_RST;
    logic [PROB_W-1:0]   rate_cfg  = INVASION_RATE_RST;

    cell_item_t          cell_todo_q[$];
    cell_fate_t          fate_q[$];
    cell_item_t          next_cell;
    cell_fate_t          want;
    int                  cells_queued   = 0;
    int                  cells_taken    = 0;
    int                  mismatch_count = 0;
    int                  burst_left     = 0;
    int                  gap_left       = 0;
    int                  cycle_count    = 0;

    lattice_invasion_cell_update_top DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .left_fitness   (left_fitness),
        .center_fitness (center_fitness),
        .right_fitness  (right_fitness),
        .gate_random    (gate_random),
        .pick_random    (pick_random),
        .done           (done),
        .new_fitness    (new_fitness),
        .replaced       (replaced),
        .chosen_side    (chosen_side),
        .write_en       (write_en),
        .reg_index      (reg_index),
        .write_data     (write_data)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Work out the fate of one cell under the current register copies
    function automatic cell_fate_t invade_cell(cell_item_t c);
        logic [79:0]     keep_share;
        logic [79:0]     pull_l;
        logic [79:0]     pull_r;
        logic [79:0]     hold_c;
        logic [79:0]     den_l;
        logic [79:0]     den_r;
        logic [PROB_W:0] str_l;
        logic [PROB_W:0] str_r;
        logic [79:0]     str_sum;
        logic [79:0]     right_side;
        logic [79:0]     left_side;
        logic            go_right;
        logic [FIT_W-1:0] chosen;
        cell_fate_t      f;
        f.new_fit      = c.center_fit;
        f.was_replaced = 1'b0;
        f.side         = 1'b0;
        if (c.gate < rate_cfg)
        begin
            keep_share = 80'(PROB_ONE) - 80'(share_cfg);
            hold_c     = keep_share * 80'(c.center_fit >> PROD_SHIFT);
            pull_l     = 80'(share_cfg) * 80'(c.left_fit >> PROD_SHIFT);
            pull_r     = 80'(share_cfg) * 80'(c.right_fit >> PROD_SHIFT);
            den_l      = pull_l + hold_c;
            den_r      = pull_r + hold_c;
            // a zero denominator leaves the strength undefined: drop the attempt
            if (den_l != 0 && den_r != 0)
            begin
                str_l   = (PROB_W+1)'((pull_l << PROB_W) / den_l);
                str_r   = (PROB_W+1)'((pull_r << PROB_W) / den_r);
                str_sum = 80'(str_l) + 80'(str_r);
                if ((80'(c.gate) << 1) <= str_sum)
                begin
                    go_right = 1'b0;
                    if (c.pick != 0)
                    begin
                        right_side = 80'(c.pick) * 80'(str_r);
                        left_side  = 80'(str_l) * (80'(PROB_ONE) - 80'(c.pick));
                        go_right   = right_side > left_side;
                    end
                    chosen = go_right ? c.right_fit : c.left_fit;
                    if (chosen != c.center_fit)
                    begin
                        f.new_fit      = chosen;
                        f.was_replaced = 1'b1;
                        f.side         = go_right;
                    end
                end
            end
        end
        return f;
    endfunction

    task automatic add_cell(input logic [FIT_W-1:0] l, input logic [FIT_W-1:0] c,
                            input logic [FIT_W-1:0] r, input logic [PROB_W-1:0] g,
                            input logic [PROB_W-1:0] p);
        cell_item_t it;
        it.left_fit   = l;
        it.center_fit = c;
        it.right_fit  = r;
        it.gate       = g;
        it.pick       = p;
        cell_todo_q = {cell_todo_q, it};
        cells_queued++;
    endtask

    // Neighbour fitness: mostly random, often tied to the center
    function automatic logic [FIT_W-1:0] neighbour_fit(logic [FIT_W-1:0] c);
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return c;
            3:       return c ^ (FIT_W'(1) << $urandom_range(0, FIT_W - 1));
            4:       return FIT_W'($urandom_range(0, 255));
            default: return FIT_W'($urandom);
        endcase
    endfunction

    task automatic random_cells(input int count);
        logic [FIT_W-1:0]  c;
        logic [PROB_W-1:0] g;
        logic [PROB_W-1:0] p;
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(0, 7))
                0:       c = '0;
                1:       c = '1;
                2:       c = FIT_W'($urandom_range(0, 255));
                default: c = FIT_W'($urandom);
            endcase
            // keep most gates under the rate so attempts go deep
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5:
                    g = (rate_cfg == 0) ? '0 : PROB_W'($urandom_range(0, rate_cfg - 1));
                6, 7:    g = PROB_W'($urandom_range(0, 4096));
                default: g = PROB_W'($urandom);
            endcase
            case ($urandom_range(0, 9))
                0:       p = '0;
                1:       p = '1;
                default: p = PROB_W'($urandom);
            endcase
            add_cell(neighbour_fit(c), c, neighbour_fit(c), g, p);
        end
    endtask

    // Write one register; only called with nothing in flight
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [PROB_W-1:0] val);
        @(posedge clk);
        write_en   <= 1'b1;
        reg_index  <= idx;
        write_data <= val;
        case (idx)
            REG_BIRTH_SHARE:   share_cfg = val;
            REG_INVASION_RATE: rate_cfg  = val;
            default:           ;
        endcase
        @(posedge clk);
        write_en <= 1'b0;
    endtask

    // Wait until every queued cell is taken and every result is back
    task automatic wait_idle();
        while (cells_taken != cells_queued || fate_q.size() != 0)
            @(posedge clk);
    endtask

    // Driver: send cells in bursts, predict each one as it is taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start          <= 1'b0;
            left_fitness   <= '0;
            center_fitness <= '0;
            right_fitness  <= '0;
            gate_random    <= '0;
            pick_random    <= '0;
        end
        else
        begin
            if (start && !busy)
            begin
                fate_q = {fate_q, invade_cell({left_fitness, center_fitness, right_fitness,
                                               gate_random, pick_random})};
                cells_taken++;
            end
            if (start && busy)
            begin
                // hold the item until the block takes it
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                start <= 1'b0;
            end
            else if (cell_todo_q.size() > 0)
            begin
                next_cell      = cell_todo_q.pop_front();
                left_fitness   <= next_cell.left_fit;
                center_fitness <= next_cell.center_fit;
                right_fitness  <= next_cell.right_fit;
                gate_random    <= next_cell.gate;
                pick_random    <= next_cell.pick;
                start          <= 1'b1;
                if (burst_left > 1)
                    burst_left--;
                else
                begin
                    burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 64)
                                                             : $urandom_range(1, 12);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            else
                start <= 1'b0;
        end
    end

    // Monitor: check each done strobe against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (fate_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: new_fitness %h replaced %b chosen_side %b",
                             new_fitness, replaced, chosen_side);
            end
            else
            begin
                want = fate_q.pop_front();
                if (new_fitness !== want.new_fit || replaced !== want.was_replaced ||
                    chosen_side !== want.side)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"mismatch: new_fitness %h/%h replaced %b/%b ",
                                  "chosen_side %b/%b (expected/actual)"},
                                 want.new_fit, new_fitness, want.was_replaced, replaced,
                                 want.side, chosen_side);
                end
            end
        end
    end

    // Guard against a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Stimulus: directed cells, then random phases under several settings
    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: p = 0.1, rate = 0.2
        add_cell('0, '0, '0, 16'd0, 16'd0);                                 // all zero
        add_cell('0, '0, 32'h0100_0000, 16'd0, 16'hFFFF);                  // zero left den
        add_cell('1, '1, '1, 16'd0, 16'd0);                                 // all max, equal
        add_cell('1, 32'd1, '1, 16'd13106, 16'd0);                          // gate just under
        add_cell('1, 32'd1, '1, 16'd13107, 16'd0);                          // gate at rate
        add_cell('1, 32'd1, '0, 16'd0, 16'hFFFF);                           // right strength 0
        add_cell('0, 32'h0100_0000, '1, 16'd0, 16'hFFFF);                  // pick goes right
        add_cell('0, 32'h0100_0000, '0, 16'd0, 16'd0);                     // zero strengths
        add_cell('0, 32'h0100_0000, '0, 16'd1, 16'd0);                     // gate over sum
        add_cell(32'h0200_0000, 32'h0200_0000, 32'h0500_0000, 16'd0, 16'hFFFF);
        add_cell(32'h0200_0000, 32'h0200_0000, 32'h0500_0000, 16'd0, 16'd0); // left equal
        add_cell(32'h0100_0000, 32'h0200_0000, 32'h0100_0000, 16'd0, 16'd32768); // tie left
        add_cell(32'h0100_0000, 32'h0200_0000, 32'h0100_0000, 16'd0, 16'd32769); // tie right
        add_cell(32'h0100_0000, 32'h0200_0000, 32'h0300_0000, 16'hFFFF, 16'd12345);
        add_cell(32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'h00FF_00FF, 16'd100, 16'd1);
        add_cell(32'h8000_0000, 32'h0000_0001, 32'h7FFF_FFFF, 16'd6000, 16'd40000);
        add_cell(32'd1, '0, 32'd1, 16'd13106, 16'd32768);                   // full strengths
        random_cells(120);
        wait_idle();

        // both registers at their top
        write_reg(REG_BIRTH_SHARE, 16'hFFFF);
        write_reg(REG_INVASION_RATE, 16'hFFFF);
        add_cell(32'd1, '1, 32'd2, 16'hFFFE, 16'hFFFF);
        add_cell('1, 32'd1, '0, 16'hFFFE, 16'd0);
        random_cells(120);
        wait_idle();

        // smallest share, gate closed
        write_reg(REG_BIRTH_SHARE, 16'd1);
        write_reg(REG_INVASION_RATE, 16'd0);
        random_cells(60);
        wait_idle();

        // share zero: only the zero-gate and zero-denominator paths remain
        write_reg(REG_BIRTH_SHARE, 16'd0);
        write_reg(REG_INVASION_RATE, 16'hFFFF);
        write_reg(REG_SPARE_A, 16'h1234);
        write_reg(REG_SPARE_B, 16'hFFFF);
        add_cell('0, '0, 32'd5, 16'd0, 16'd0);
        add_cell(32'd5, 32'd7, 32'd9, 16'd0, 16'd0);
        add_cell(32'd5, 32'd7, 32'd9, 16'd1, 16'd0);
        random_cells(100);
        wait_idle();

        // half share, three-quarter rate
        write_reg(REG_BIRTH_SHARE, 16'h8000);
        write_reg(REG_INVASION_RATE, 16'hC000);
        random_cells(140);
        wait_idle();

        // random settings, with stray writes to the spare indexes
        for (int k = 0; k < 3; k++)
        begin
            write_reg(REG_BIRTH_SHARE, PROB_W'($urandom_range(1, 65535)));
            write_reg(REG_INVASION_RATE, PROB_W'($urandom));
            write_reg(($urandom_range(0, 1) == 0) ? REG_SPARE_A : REG_SPARE_B,
                      PROB_W'($urandom));
            random_cells(100);
            wait_idle();
        end

        // catch any stray strobes after the last result
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
